// ===== src/psb_pkg.sv =====
package psb_pkg;

	localparam int AddrW = 5;
	localparam int DataW = 32;

	typedef enum logic [2:0] {
		REG_DRAW_MODE,
		REG_CLIP_TL,
		REG_CLIP_BR,
		REG_MASK_CTRL,
		REG_DISP_ORIGIN,
		REG_DISP_SIZE,
		REG_DISP_FLAGS
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CLIPPED,
		ST_MASKED,
		ST_CLEAR_TEXEL,
		ST_WRITTEN
	} status_t;

	typedef enum logic [1:0] {
		BL_AVERAGE,
		BL_ADD,
		BL_SUB,
		BL_QUARTER
	} blend_t;

	localparam int DmBlendLo = 5;
	localparam int DmDither  = 9;
	localparam int DmDispOk  = 10;
	localparam int MaskBit   = 15;

	typedef struct packed {
		logic [13:0] draw_mode;
		logic [18:0] clip_tl;
		logic [18:0] clip_br;
		logic [1:0]  mask_ctrl;
		logic [18:0] disp_origin;
		logic [20:0] disp_size;
		logic [2:0]  disp_flags;
	} cfg_t;

	localparam logic [13:0] DrawModeRst   = 14'd0;
	localparam logic [18:0] ClipTlRst     = 19'd0;
	localparam logic [18:0] ClipBrRst     = 19'h7FFFF;
	localparam logic [1:0]  MaskCtrlRst   = 2'd0;
	localparam logic [18:0] DispOriginRst = 19'd0;
	localparam logic [20:0] DispSizeRst   = 21'd1025;
	localparam logic [2:0]  DispFlagsRst  = 3'd0;

	// Ordered 4x4 dither offset, indexed by the low two bits of row and column.
	function automatic logic signed [3:0] dither_delta(input logic [1:0] row,
			input logic [1:0] col);
		logic signed [3:0] d;
		case ({row, col})
			4'h0: d = -4'sd4;
			4'h1: d = 4'sd0;
			4'h2: d = -4'sd3;
			4'h3: d = 4'sd1;
			4'h4: d = 4'sd2;
			4'h5: d = -4'sd2;
			4'h6: d = 4'sd3;
			4'h7: d = -4'sd1;
			4'h8: d = -4'sd3;
			4'h9: d = 4'sd1;
			4'hA: d = -4'sd4;
			4'hB: d = 4'sd0;
			4'hC: d = 4'sd3;
			4'hD: d = -4'sd1;
			4'hE: d = 4'sd2;
			4'hF: d = -4'sd2;
			default: d = 4'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== src/psb_if.sv =====
interface psb_in_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] pos_x;
	logic signed [11:0] pos_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [15:0]        texel;
	logic [15:0]        background;
	logic               is_textured;
	logic               is_raw;
	logic               is_transparent;
	logic               want_dither;

	modport source (output valid, pos_x, pos_y, red, green, blue, texel, background,
		is_textured, is_raw, is_transparent, want_dither, input ready);
	modport sink (input valid, pos_x, pos_y, red, green, blue, texel, background,
		is_textured, is_raw, is_transparent, want_dither, output ready);
endinterface

interface psb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] pixel_word;

	modport source (output valid, status, pixel_word, input ready);
	modport sink (input valid, status, pixel_word, output ready);
endinterface

// ===== src/psb_regs.sv =====
module psb_regs
	import psb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.draw_mode   <= DrawModeRst;
			cfg_q.clip_tl     <= ClipTlRst;
			cfg_q.clip_br     <= ClipBrRst;
			cfg_q.mask_ctrl   <= MaskCtrlRst;
			cfg_q.disp_origin <= DispOriginRst;
			cfg_q.disp_size   <= DispSizeRst;
			cfg_q.disp_flags  <= DispFlagsRst;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_DRAW_MODE:   cfg_q.draw_mode   <= pwdata[13:0];
				REG_CLIP_TL:     cfg_q.clip_tl     <= pwdata[18:0];
				REG_CLIP_BR:     cfg_q.clip_br     <= pwdata[18:0];
				REG_MASK_CTRL:   cfg_q.mask_ctrl   <= pwdata[1:0];
				REG_DISP_ORIGIN: cfg_q.disp_origin <= pwdata[18:0];
				REG_DISP_SIZE:   cfg_q.disp_size   <= pwdata[20:0];
				REG_DISP_FLAGS:  cfg_q.disp_flags  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DRAW_MODE:   prdata = {18'd0, cfg_q.draw_mode};
			REG_CLIP_TL:     prdata = {13'd0, cfg_q.clip_tl};
			REG_CLIP_BR:     prdata = {13'd0, cfg_q.clip_br};
			REG_MASK_CTRL:   prdata = {30'd0, cfg_q.mask_ctrl};
			REG_DISP_ORIGIN: prdata = {13'd0, cfg_q.disp_origin};
			REG_DISP_SIZE:   prdata = {11'd0, cfg_q.disp_size};
			REG_DISP_FLAGS:  prdata = {29'd0, cfg_q.disp_flags};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== src/psb_pipe.sv =====
module psb_pipe
	import psb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	psb_in_if.sink    pix_in,
	psb_out_if.source pix_out
);

	// Stage 1: clipping, skip tests and per-pixel flags.
	logic [9:0]  xx;
	logic [8:0]  yy;
	logic [9:0]  dx;
	logic [8:0]  dy;
	logic [11:0] x_end;
	logic [10:0] y_end;
	logic        out_frame;
	logic        out_area;
	logic        wrong_field;
	logic        in_disp;
	status_t     status_in;

	logic              valid_s1;
	status_t           status_s1;
	logic              blend_s1;
	logic              mask_s1;
	logic signed [3:0] delta_s1;
	logic              textured_s1;
	logic              raw_s1;
	logic [14:0]       texel_s1;
	logic [14:0]       back_s1;
	logic [2:0][7:0]   col_s1;

	// Stage 2: modulation and dither.
	logic [2:0][12:0]        prod;
	logic [2:0][4:0]         src;
	logic signed [2:0][10:0] shade;
	logic [2:0][4:0]         fore;

	logic            valid_s2;
	status_t         status_s2;
	logic            blend_s2;
	logic            mask_s2;
	logic [14:0]     back_s2;
	logic [2:0][4:0] fore_s2;

	// Stage 3: blend and pack.
	blend_t          mode;
	logic [2:0][4:0] bch;
	logic [2:0][5:0] acc;
	logic [2:0][4:0] mixed;
	logic [15:0]     word;

	logic        valid_s3;
	logic [1:0]  status_s3;
	logic [15:0] word_s3;

	logic adv_s1;
	logic adv_s2;
	logic adv_s3;

	assign adv_s3       = !valid_s3 || pix_out.ready;
	assign adv_s2       = !valid_s2 || adv_s3;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign pix_in.ready = adv_s1;

	always_comb begin
		xx    = pix_in.pos_x[9:0];
		yy    = pix_in.pos_y[8:0];
		dx    = cfg.disp_origin[9:0];
		dy    = cfg.disp_origin[18:10];
		x_end = {2'b00, dx} + {1'b0, cfg.disp_size[10:0]};
		y_end = {2'b00, dy} + {1'b0, cfg.disp_size[20:11]};
		out_frame = pix_in.pos_x[11] || pix_in.pos_x[10] || pix_in.pos_y[11] ||
			pix_in.pos_y[10] || pix_in.pos_y[9];
		out_area = (xx < cfg.clip_tl[9:0]) || (yy < cfg.clip_tl[18:10]) ||
			(xx > cfg.clip_br[9:0]) || (yy > cfg.clip_br[18:10]);
		wrong_field = cfg.disp_flags[1] && (yy[0] == cfg.disp_flags[2]);
		in_disp = cfg.disp_flags[0] && !cfg.draw_mode[DmDispOk] && (xx >= dx) &&
			(yy >= dy) && ({2'b00, xx} < x_end) && ({2'b00, yy} < y_end);
		if (out_frame || out_area || wrong_field || in_disp) begin
			status_in = ST_CLIPPED;
		end else if (cfg.mask_ctrl[1] && pix_in.background[MaskBit]) begin
			status_in = ST_MASKED;
		end else if (pix_in.is_textured && (pix_in.texel == 16'd0)) begin
			status_in = ST_CLEAR_TEXEL;
		end else begin
			status_in = ST_WRITTEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pix_in.valid) begin
			status_s1   <= status_in;
			blend_s1    <= pix_in.is_transparent &&
				(!pix_in.is_textured || pix_in.texel[MaskBit]);
			mask_s1     <= cfg.mask_ctrl[0] || (pix_in.is_textured && pix_in.texel[MaskBit]);
			delta_s1    <= (pix_in.want_dither && cfg.draw_mode[DmDither]) ?
				dither_delta(pix_in.pos_y[1:0], pix_in.pos_x[1:0]) : 4'sd0;
			textured_s1 <= pix_in.is_textured;
			raw_s1      <= pix_in.is_raw;
			texel_s1    <= pix_in.texel[14:0];
			back_s1     <= pix_in.background[14:0];
			col_s1      <= {pix_in.blue, pix_in.green, pix_in.red};
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			src[ch]  = texel_s1[ch*5 +: 5];
			prod[ch] = {8'd0, src[ch]} * {5'd0, col_s1[ch]};
			if (textured_s1) begin
				shade[ch] = $signed({2'b00, prod[ch][12:4]}) + 11'(delta_s1);
			end else begin
				shade[ch] = $signed({3'b000, col_s1[ch]}) + 11'(delta_s1);
			end
			if (textured_s1 && raw_s1) begin
				fore[ch] = src[ch];
			end else if (shade[ch][10]) begin
				fore[ch] = 5'd0;
			end else if (shade[ch][9:8] != 2'b00) begin
				fore[ch] = 5'd31;
			end else begin
				fore[ch] = shade[ch][7:3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			status_s2 <= status_s1;
			blend_s2  <= blend_s1;
			mask_s2   <= mask_s1;
			back_s2   <= back_s1;
			fore_s2   <= fore;
		end
	end

	always_comb begin
		mode = blend_t'(cfg.draw_mode[DmBlendLo +: 2]);
		for (int ch = 0; ch < 3; ch++) begin
			bch[ch] = back_s2[ch*5 +: 5];
			case (mode)
				BL_AVERAGE: acc[ch] = {1'b0, bch[ch]} + {1'b0, fore_s2[ch]};
				BL_ADD:     acc[ch] = {1'b0, bch[ch]} + {1'b0, fore_s2[ch]};
				BL_SUB:     acc[ch] = {1'b0, bch[ch]} - {1'b0, fore_s2[ch]};
				BL_QUARTER: acc[ch] = {1'b0, bch[ch]} + {3'b000, fore_s2[ch][4:2]};
				default:    acc[ch] = '0;
			endcase
			if (!blend_s2) begin
				mixed[ch] = fore_s2[ch];
			end else if (mode == BL_AVERAGE) begin
				mixed[ch] = acc[ch][5:1];
			end else if (mode == BL_SUB) begin
				mixed[ch] = acc[ch][5] ? 5'd0 : acc[ch][4:0];
			end else begin
				mixed[ch] = acc[ch][5] ? 5'd31 : acc[ch][4:0];
			end
		end
		word = (status_s2 == ST_WRITTEN) ? {mask_s2, mixed[2], mixed[1], mixed[0]} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			status_s3 <= status_s2;
			word_s3   <= word;
		end
	end

	assign pix_out.valid      = valid_s3;
	assign pix_out.status     = status_s3;
	assign pix_out.pixel_word = word_s3;

endmodule

// ===== src/pixel_shade_blend.sv =====
// An accepted word passes through the three pipeline registers, stage 1 to stage 3.
// Throughput: one word per cycle without output stalls; each register holds one word.
// A stalled output holds the occupied stages while empty ones still fill, so input ready
// drops only when all three stages are full and the output is stalled.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
module pixel_shade_blend
	import psb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	psb_in_if.sink           pix_in,
	psb_out_if.source        pix_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	cfg_t cfg;

	psb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psb_pipe u_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && (pix_out.status != ST_WRITTEN) |-> (pix_out.pixel_word == 16'd0))
		else $error("skipped pixel carries a nonzero word");

	a_force_mask: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && (pix_out.status == ST_WRITTEN) && cfg.mask_ctrl[0]
		|-> pix_out.pixel_word[MaskBit])
		else $error("forced mask bit missing");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (pix_out.valid && !pix_out.ready))
		else $error("input stalled without output backpressure");

endmodule
